>>> src/assert_macros.svh
// Assertion macros used by the region table RTL.
// Depends on nothing; included by address_region_table_unit to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ART_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ART_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ART_ASSERT(lbl, clk, rst_n, prop)
`define ART_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> src/art_pkg.sv
// Shared types and codes of the address region table.
// Depends on nothing; used by art_cell and address_region_table_unit.
`default_nettype none
package art_pkg;

    localparam int ADDR_BITS   = 48;
    localparam int LEN_BITS    = 31;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_BITS-1:0]  length;
    } t_cmd;

    typedef struct packed {
        logic                in_region;
        logic [STAT_W-1:0]   status;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] start;
        logic [LEN_BITS-1:0]  length;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> src/art_cell.sv
// One table slot: holds a region, compares it against the probe address,
// and takes its upper neighbor's contents on a remove shift.
// Depends on art_pkg.
`default_nettype none
module art_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire art_pkg::t_cell_ctl i_ctl,
    input  wire art_pkg::t_entry    i_new,
    input  wire art_pkg::t_entry    i_next,
    input  wire logic [art_pkg::ADDR_BITS-1:0] i_probe,
    output art_pkg::t_entry         o_entry,
    output logic                    o_start_eq,
    output logic                    o_covers
);
    localparam int AW    = art_pkg::ADDR_BITS;
    localparam int CMP_W = (art_pkg::ADDR_BITS > art_pkg::LEN_BITS) ?
                           art_pkg::ADDR_BITS : art_pkg::LEN_BITS;

    logic                         r_valid;
    logic [AW-1:0]                r_start;
    logic [art_pkg::LEN_BITS-1:0] r_length;
    logic [AW:0]                  diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_start  <= i_next.start;
            r_length <= i_next.length;
        end else if (i_ctl.load) begin
            r_start  <= i_new.start;
            r_length <= i_new.length;
        end
    end

    // borrow in the top bit means probe < start
    assign diff = {1'b0, i_probe} - {1'b0, r_start};

    assign o_start_eq = r_valid && (r_start == i_probe);
    assign o_covers   = r_valid && !diff[AW] &&
                        (CMP_W'(diff[AW-1:0]) < CMP_W'(r_length));

    assign o_entry.valid  = r_valid;
    assign o_entry.start  = r_start;
    assign o_entry.length = r_length;
endmodule
`default_nettype wire

>>> src/address_region_table_unit.sv
// Address region table: top level, a row of art_cell slots plus command decode.
// Depends on art_pkg, art_cell and assert_macros.svh.
//
// One command (insert, remove by start, lookup) is taken per clock while busy
// is low; busy is high only during reset and the cycle after it. The result
// appears in the cycle after the command transfer, on o_result with o_strobe
// high for exactly one cycle; the receiver cannot stall it. Every slot compares
// the probe address in parallel, and a remove shifts the younger slots down in
// the same cycle, so the table takes one command per cycle while busy is low.
`default_nettype none
module address_region_table_unit #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire art_pkg::t_cmd i_item,
    output logic               busy,
    output logic               o_strobe,
    output art_pkg::t_rsp      o_result
);
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = (CNT_W > art_pkg::COUNT_W) ? CNT_W : art_pkg::COUNT_W;

    logic                         r_busy;
    logic                         r_strobe;
    art_pkg::t_rsp                r_result;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         accept;
    logic                         is_ins;
    logic                         is_rem;
    logic                         is_look;
    logic                         full;
    logic                         found;
    logic [ENTRIES-1:0]           start_eq;
    logic [ENTRIES-1:0]           covers;
    logic [ENTRIES-1:0]           valid_vec;
    logic [ENTRIES-1:0]           load_vec;
    logic [art_pkg::STAT_W-1:0]   status;
    art_pkg::t_entry              new_entry;
    art_pkg::t_entry              entries [ENTRIES];
    art_pkg::t_cell_ctl           ctl [ENTRIES];

    assign accept  = start && !r_busy;
    assign is_ins  = i_item.command == art_pkg::CMD_INSERT;
    assign is_rem  = i_item.command == art_pkg::CMD_REMOVE;
    assign is_look = i_item.command == art_pkg::CMD_LOOKUP;
    assign full    = r_count == CNT_W'(ENTRIES);
    assign found   = |start_eq;

    assign new_entry.valid  = 1'b1;
    assign new_entry.start  = i_item.address;
    assign new_entry.length = i_item.length;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        localparam logic [ENTRIES-1:0] LOW_MASK = {ENTRIES{1'b1}} >> (ENTRIES - 1 - k);
        art_pkg::t_entry next_entry;

        if (k == ENTRIES - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = entries[k + 1];
        end

        // shift from the oldest matching slot upward
        assign ctl[k].shift = accept && is_rem && (|(start_eq & LOW_MASK));
        assign ctl[k].load  = accept && is_ins && !full && (r_count == CNT_W'(k));
        assign load_vec[k]  = ctl[k].load;
        assign valid_vec[k] = entries[k].valid;

        art_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[k]),
            .i_new      (new_entry),
            .i_next     (next_entry),
            .i_probe    (i_item.address),
            .o_entry    (entries[k]),
            .o_start_eq (start_eq[k]),
            .o_covers   (covers[k])
        );
    end

    always_comb begin
        n_count = r_count;
        status  = art_pkg::ST_OK;
        priority if (is_ins) begin
            if (full) begin
                status = art_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (is_rem) begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                status = art_pkg::ST_NOT_FOUND;
            end
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result.in_region   <= is_look && (|covers);
            r_result.status      <= status;
            r_result.entry_count <= art_pkg::COUNT_W'(EXT_W'(n_count));
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ART_ASSERT(a_count_matches_valid, i_clk, i_rst_n,
        $countones(valid_vec) == int'(r_count))
    `ART_ASSERT(a_valid_packed, i_clk, i_rst_n,
        ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    `ART_ASSERT(a_single_load, i_clk, i_rst_n, $onehot0(load_vec))
    `ART_ASSERT(a_remove_decrements, i_clk, i_rst_n,
        accept && is_rem && found |=> r_count == $past(r_count) - CNT_W'(1))
    `ART_NEVER(a_load_when_full, i_clk, i_rst_n, full && (|load_vec))
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for address_region_table_unit: directed and random
// insert/remove/lookup transfers checked against a shadow region table.
// Depends on art_pkg and address_region_table_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int TBL_DEPTH   = art_pkg::ENTRIES_DEF;
    localparam int N_USEFUL    = 1100;
    localparam int CYCLE_LIMIT = 60000;
    localparam int AW          = art_pkg::ADDR_BITS;
    localparam int LW          = art_pkg::LEN_BITS;
    localparam logic [art_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [AW-1:0]             ADDR_MAX   = '1;
    localparam logic [LW-1:0]             LEN_MAX    = '1;

    typedef struct {
        art_pkg::t_cmd cmd;
        int unsigned   gap;
        bit            drain;
    } t_cmd_slot;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    art_pkg::t_cmd i_item  = '0;
    logic          busy;
    logic          o_strobe;
    art_pkg::t_rsp o_result;

    t_cmd_slot     cmd_queue[$];
    art_pkg::t_rsp predicted_results[$];

    // shadow of the table, kept packed in insertion order
    logic [AW-1:0] shadow_start[TBL_DEPTH];
    logic [LW-1:0] shadow_len[TBL_DEPTH];
    int            shadow_count = 0;

    // stimulus-side view of the table, used to aim removes and lookups
    logic [AW-1:0] gen_starts[$];
    logic [LW-1:0] gen_lens[$];
    bit            burst_mode = 1'b0;

    int unsigned gap_left   = 0;
    bit          gap_armed  = 1'b0;
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;
    int          n_checked  = 0;
    int          n_insert   = 0;
    int          n_full     = 0;
    int          n_remove   = 0;
    int          n_notfound = 0;
    int          n_lookup   = 0;
    int          n_hit      = 0;

    address_region_table_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic art_pkg::t_rsp table_apply(art_pkg::t_cmd c);
        art_pkg::t_rsp r;
        int            found;
        r = '0;
        case (c.command)
            art_pkg::CMD_INSERT: begin
                n_insert++;
                if (shadow_count >= TBL_DEPTH) begin
                    r.status = art_pkg::ST_FULL;
                    n_full++;
                end else begin
                    shadow_start[shadow_count] = c.address;
                    shadow_len[shadow_count]   = c.length;
                    shadow_count++;
                end
            end
            art_pkg::CMD_REMOVE: begin
                n_remove++;
                found = -1;
                for (int k = 0; k < shadow_count; k++) begin
                    if (found < 0 && shadow_start[k] == c.address) found = k;
                end
                if (found < 0) begin
                    r.status = art_pkg::ST_NOT_FOUND;
                    n_notfound++;
                end else begin
                    for (int k = found; k < shadow_count - 1; k++) begin
                        shadow_start[k] = shadow_start[k+1];
                        shadow_len[k]   = shadow_len[k+1];
                    end
                    shadow_count--;
                end
            end
            art_pkg::CMD_LOOKUP: begin
                n_lookup++;
                for (int k = 0; k < shadow_count; k++) begin
                    if (c.address >= shadow_start[k] &&
                        (c.address - shadow_start[k]) < {17'b0, shadow_len[k]})
                        r.in_region = 1'b1;
                end
                if (r.in_region) n_hit++;
            end
            default: ;
        endcase
        r.entry_count = art_pkg::COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [AW-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return AW'($urandom_range(0, 4096));
            1:       return ADDR_MAX - AW'($urandom_range(0, 4096));
            default: return w[AW-1:0];
        endcase
    endfunction

    function automatic logic [LW-1:0] rand_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LW'(1);
            2:       return LEN_MAX;
            3, 4:    return LW'($urandom_range(1, 4096));
            default: return LW'($urandom);
        endcase
    endfunction

    task automatic push_cmd(input logic [art_pkg::CMD_W-1:0] op, input logic [AW-1:0] a,
                            input logic [LW-1:0] l, input bit hold);
        t_cmd_slot s;
        s.cmd.command = op;
        s.cmd.address = a;
        s.cmd.length  = l;
        s.gap         = burst_mode ? 0 : $urandom_range(0, 3);
        s.drain       = hold;
        cmd_queue.insert(cmd_queue.size(), s);
        if (op == art_pkg::CMD_INSERT && gen_starts.size() < TBL_DEPTH) begin
            gen_starts.insert(gen_starts.size(), a);
            gen_lens.insert(gen_lens.size(), l);
        end else if (op == art_pkg::CMD_REMOVE) begin
            for (int k = 0; k < gen_starts.size(); k++) begin
                if (gen_starts[k] == a) begin
                    gen_starts.delete(k);
                    gen_lens.delete(k);
                    break;
                end
            end
        end
    endtask

    // stimulus
    initial begin
        int            n_useful;
        int            roll;
        int            ins_w;
        int            rem_w;
        int            k;
        logic [AW-1:0] s;
        logic [LW-1:0] l;
        logic [AW-1:0] a;

        // directed: empty table, unused code, boundaries, no wrap, duplicates, full
        push_cmd(art_pkg::CMD_LOOKUP, '0, '0, 1'b0);
        push_cmd(art_pkg::CMD_REMOVE, 48'h1234, '0, 1'b0);
        push_cmd(CMD_UNUSED, ADDR_MAX, LEN_MAX, 1'b0);
        push_cmd(art_pkg::CMD_INSERT, '0, '0, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, '0, '0, 1'b0);
        push_cmd(art_pkg::CMD_INSERT, 48'h1000, 31'h10, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, 48'h100f, LEN_MAX, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, 48'h1010, '0, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, 48'h0fff, '0, 1'b0);
        push_cmd(art_pkg::CMD_INSERT, ADDR_MAX - 3, LEN_MAX, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, ADDR_MAX, '0, 1'b0);
        push_cmd(art_pkg::CMD_INSERT, 48'h1000, LEN_MAX, 1'b0);
        push_cmd(art_pkg::CMD_REMOVE, 48'h1000, '0, 1'b0);
        push_cmd(art_pkg::CMD_LOOKUP, 48'h1010, '0, 1'b0);
        for (int i = 0; i < TBL_DEPTH - 3; i++)
            push_cmd(art_pkg::CMD_INSERT, 48'h10000 * (i + 1), 31'h100, 1'b0);
        push_cmd(art_pkg::CMD_INSERT, 48'h5000, 31'h1, 1'b1);

        n_useful = 0;
        for (int i = 0; n_useful < N_USEFUL; i++) begin
            if (i % 48 == 0) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0:       begin ins_w = 55; rem_w = 15; end
                    1:       begin ins_w = 35; rem_w = 25; end
                    default: begin ins_w = 20; rem_w = 45; end
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < ins_w) begin
                if (gen_starts.size() != 0 && $urandom_range(0, 4) == 0)
                    s = gen_starts[$urandom_range(0, gen_starts.size() - 1)];
                else
                    s = rand_addr();
                push_cmd(art_pkg::CMD_INSERT, s, rand_len(),
                         i == 0 || $urandom_range(0, 199) == 0);
                n_useful++;
            end else if (roll < ins_w + rem_w) begin
                if (gen_starts.size() != 0 && $urandom_range(0, 4) != 0)
                    s = gen_starts[$urandom_range(0, gen_starts.size() - 1)];
                else
                    s = rand_addr();
                push_cmd(art_pkg::CMD_REMOVE, s, rand_len(),
                         i == 0 || $urandom_range(0, 199) == 0);
                n_useful++;
            end else if (roll < 97) begin
                if (gen_starts.size() != 0 && $urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, gen_starts.size() - 1);
                    s = gen_starts[k];
                    l = gen_lens[k];
                    case ($urandom_range(0, 4))
                        0:       a = s;
                        1:       a = s + l - 1;
                        2:       a = s + l;
                        3:       a = s - 1;
                        default: a = s + AW'($urandom_range(0, l));
                    endcase
                end else begin
                    a = rand_addr();
                end
                push_cmd(art_pkg::CMD_LOOKUP, a, rand_len(),
                         i == 0 || $urandom_range(0, 199) == 0);
                n_useful++;
            end else begin
                push_cmd(CMD_UNUSED, rand_addr(), rand_len(), 1'b0);
            end
        end
    end

    // driver
    always @(posedge i_clk) begin
        logic nxt_start;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (start && !busy) begin
                predicted_results.insert(predicted_results.size(), table_apply(i_item));
                void'(cmd_queue.pop_front());
                nxt_start = 1'b0;
                gap_armed = 1'b0;
            end
            if (!nxt_start && cmd_queue.size() != 0) begin
                if (!gap_armed) begin
                    gap_left  = cmd_queue[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!cmd_queue[0].drain || predicted_results.size() == 0) begin
                    nxt_start = 1'b1;
                    i_item   <= cmd_queue[0].cmd;
                end
            end
        end
        start <= nxt_start;
    end

    // monitor
    always @(posedge i_clk) begin
        art_pkg::t_rsp exp_r;
        if (i_rst_n && o_strobe) begin
            if (predicted_results.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", o_result);
                fail_cnt++;
            end else begin
                exp_r = predicted_results.pop_front();
                n_checked++;
                if (o_result.in_region !== exp_r.in_region) begin
                    $error("in_region: expected %0d, got %0d", exp_r.in_region,
                           o_result.in_region);
                    fail_cnt++;
                end
                if (o_result.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_result.status);
                    fail_cnt++;
                end
                if (o_result.entry_count !== exp_r.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                           o_result.entry_count);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("address_region_table_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (cmd_queue.size() != 0 || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("checked %0d results: %0d inserts (%0d full), %0d removes (%0d not found),",
                 n_checked, n_insert, n_full, n_remove, n_notfound);
        $display("%0d lookups (%0d hits), idle gaps and a drain pause included",
                 n_lookup, n_hit);
        if (fail_cnt == 0)
            $display("address_region_table_unit regression: pass");
        else
            $display("address_region_table_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
+incdir+src
src/art_pkg.sv
src/art_cell.sv
src/address_region_table_unit.sv
dv/tb_top.sv
